// ===== src/adpcm_pkg.sv =====
// ---------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants for the multichannel 4-bit DSP ADPCM decoder.
// ---------------------------------------------------------------------------
package adpcm_pkg;

   // Operation carried in req_tuser
   typedef enum logic [1:0] {
      OP_LOAD_COEF = 2'd0,
      OP_HEADER    = 2'd1,
      OP_DATA      = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   localparam int SAMPLE_W     = 16;
   localparam int NIB_W        = 4;
   localparam int EXP_W        = 4;
   localparam int HDR_W        = 7;    // header bit 7 is reserved and dropped
   localparam int PAIR_IDX_W   = 3;    // eight coefficient pairs per channel
   localparam int FRAC_BITS    = 11;
   localparam int ROUND_BIAS   = 1024;
   localparam int SAMPLE_MAX   = 32767;
   localparam int SAMPLE_MIN   = -32768;
   localparam int PROD_W       = 32;
   localparam int ACC_W        = 34;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 24;

   // One coefficient pair, even slot in the low half
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] c2;
      logic signed [SAMPLE_W-1:0] c1;
   } coef_pair_type;

   // Two-sample history, most recent sample in the low half
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] h2;
      logic signed [SAMPLE_W-1:0] h1;
   } hist_pair_type;

   // Datapath control from the sequencer
   typedef struct packed {
      logic load;     // multiply stage: capture operands and products
      logic first;    // first nibble: operands straight from the memories
      logic advance;  // sample taken: shift the history
   } dp_ctl_type;

endpackage

// ===== src/dsp_adpcm_decoder.sv =====
// ---------------------------------------------------------------------------
// dsp_adpcm_decoder
// Multichannel 4-bit DSP ADPCM decoder: coefficient loads, frame headers,
// data bytes of one or two nibbles, history clears, per channel.
// ---------------------------------------------------------------------------
//
//  channel  dir  payload                                            marker
//  -------  ---  -------------------------------------------------  -------
//  req_     in   tdata: channel, data_byte, sample_count,           tuser:
//                coef_slot, coef_value                              operation
//  rsp_     out  tdata: out_channel, sample                         tlast
//
//  Load, header and clear complete in their transfer cycle. A data byte
//  is taken in its transfer cycle and then decodes one or two samples. Each
//  sample is a multiply stage then a sum/saturate stage on the shared pair
//  of 16x16 multipliers, and the second sample needs the first as its
//  history. Synchronous active-high reset clears the header registers and
//  history valid bits; coefficients stay undefined until loaded. A full
//  result register with rsp_tready low holds the sum stage.
//
module dsp_adpcm_decoder #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // channel[2:0], data_byte[10:3],
                                    // sample_count[12:11], coef_slot[16:13],
                                    // coef_value[32:17], zero fill
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_channel[2:0], sample[18:3], zero fill
   output logic        rsp_tlast    // last sample of the item
);

   localparam int ChanIdxW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CoefAw    = ChanIdxW + adpcm_pkg::PAIR_IDX_W;
   localparam int CoefDepth = MAX_CHANNELS * 8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   // request field unpack
   logic [2:0]                            req_channel;
   logic [7:0]                            req_data_byte;
   logic [1:0]                            req_sample_count;
   logic [3:0]                            req_coef_slot;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] req_coef_value;
   adpcm_pkg::op_type                     req_op;

   assign req_channel      = req_tdata[2:0];
   assign req_data_byte    = req_tdata[10:3];
   assign req_sample_count = req_tdata[12:11];
   assign req_coef_slot    = req_tdata[16:13];
   assign req_coef_value   = req_tdata[32:17];
   assign req_op           = adpcm_pkg::op_type'(req_tuser);

   state_type state_ff, state_in;

   logic [31:0]                  req_ch_wide;
   logic [ChanIdxW-1:0]          req_ch_idx;
   logic                         req_ch_ok;
   logic                         accept;
   logic                         start_data;
   logic [adpcm_pkg::HDR_W-1:0]  hdr_ff [MAX_CHANNELS];
   logic [adpcm_pkg::HDR_W-1:0]  hdr_sel;

   // item registers for the data byte in flight
   logic [2:0]                   chan_ff;
   logic [7:0]                   byte_ff;
   logic                         two_ff;     // two nibbles to decode
   logic                         sel_ff;     // working on the low nibble
   logic [adpcm_pkg::EXP_W-1:0]  expo_ff;
   logic [31:0]                  chan_wide;
   logic [ChanIdxW-1:0]          item_ch_idx;

   // result register
   logic                                  rsp_valid_ff;
   logic [2:0]                            rsp_chan_ff;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                  rsp_last_ff;
   logic                                  out_free;
   logic                                  emit;
   logic                                  item_done;

   adpcm_pkg::coef_pair_type              coef_rd;
   adpcm_pkg::hist_pair_type              hist_rd;
   adpcm_pkg::hist_pair_type              hist_next;
   adpcm_pkg::dp_ctl_type                 dp_ctl;
   logic signed [adpcm_pkg::SAMPLE_W-1:0] sample;
   logic [adpcm_pkg::NIB_W-1:0]           nibble;

   assign req_ch_wide = 32'(req_channel);
   assign req_ch_idx  = req_ch_wide[ChanIdxW-1:0];
   assign req_ch_ok   = req_ch_wide < 32'(MAX_CHANNELS);
   assign chan_wide   = 32'(chan_ff);
   assign item_ch_idx = chan_wide[ChanIdxW-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign hdr_sel    = hdr_ff[req_ch_idx];
   assign start_data = accept && req_ch_ok && (req_op == adpcm_pkg::OP_DATA)
                       && (req_sample_count != 2'd0);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = (state_ff == ST_SUM) && out_free;
   assign item_done = emit && (sel_ff || !two_ff);
   assign nibble    = sel_ff ? byte_ff[3:0] : byte_ff[7:4];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_data) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (emit) begin
               state_in = item_done ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // frame headers: exponent in bits 3:0, pair index in bits 6:4
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            hdr_ff[i] <= '0;
         end
      end else if (accept && req_ch_ok && (req_op == adpcm_pkg::OP_HEADER)) begin
         hdr_ff[req_ch_idx] <= req_data_byte[adpcm_pkg::HDR_W-1:0];
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (start_data) begin
         chan_ff <= req_channel;
         byte_ff <= req_data_byte;
         two_ff  <= req_sample_count[1];
         expo_ff <= hdr_sel[adpcm_pkg::EXP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else if (start_data) begin
         sel_ff <= 1'b0;
      end else if (emit && !item_done) begin
         sel_ff <= 1'b1;
      end
   end

   // result register, refilled while the previous transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= sample;
         rsp_last_ff   <= sel_ff || !two_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_sample_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;

   // memories: both read at the request transfer; history written back at item end
   adpcm_coef_mem #(
      .DEPTH (CoefDepth),
      .AW    (CoefAw)
   ) u_coef_mem (
      .clock   (clock),
      .wr_lo   (accept && req_ch_ok && (req_op == adpcm_pkg::OP_LOAD_COEF)
                && !req_coef_slot[0]),
      .wr_hi   (accept && req_ch_ok && (req_op == adpcm_pkg::OP_LOAD_COEF)
                && req_coef_slot[0]),
      .wr_addr ({req_ch_idx, req_coef_slot[3:1]}),
      .wr_data (req_coef_value),
      .rd_en   (start_data),
      .rd_addr ({req_ch_idx, hdr_sel[adpcm_pkg::HDR_W-1:adpcm_pkg::EXP_W]}),
      .rd_data (coef_rd)
   );

   adpcm_hist_mem #(
      .DEPTH (MAX_CHANNELS),
      .AW    (ChanIdxW)
   ) u_hist_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (start_data),
      .rd_addr  (req_ch_idx),
      .rd_data  (hist_rd),
      .wr_en    (item_done),
      .wr_addr  (item_ch_idx),
      .wr_data  (hist_next),
      .clr_en   (accept && req_ch_ok && (req_op == adpcm_pkg::OP_CLEAR)),
      .clr_addr (req_ch_idx)
   );

   // datapath control
   always_comb begin
      dp_ctl.load    = (state_ff == ST_MUL);
      dp_ctl.first   = !sel_ff;
      dp_ctl.advance = emit;
   end

   adpcm_dp u_dp (
      .clock     (clock),
      .ctl       (dp_ctl),
      .nibble    (nibble),
      .expo      (expo_ff),
      .coef_rd   (coef_rd),
      .hist_rd   (hist_rd),
      .sample    (sample),
      .hist_next (hist_next)
   );

endmodule

// ===== src/adpcm_coef_mem.sv =====
// ---------------------------------------------------------------------------
// adpcm_coef_mem
// Predictor coefficient store, one coefficient pair per word, with a write
// enable for each half and a registered read port.
// ---------------------------------------------------------------------------
module adpcm_coef_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                             clock,
   input  logic                             wr_lo,
   input  logic                             wr_hi,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [adpcm_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output adpcm_pkg::coef_pair_type         rd_data
);

   adpcm_pkg::coef_pair_type mem [DEPTH];
   adpcm_pkg::coef_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_lo) begin
         mem[wr_addr].c1 <= wr_data;
      end
      if (wr_hi) begin
         mem[wr_addr].c2 <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/adpcm_hist_mem.sv =====
// ---------------------------------------------------------------------------
// adpcm_hist_mem
// Per-channel two-sample history store with registered read. A valid bit per
// channel makes unwritten or cleared entries read as zero.
// ---------------------------------------------------------------------------
module adpcm_hist_mem #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output adpcm_pkg::hist_pair_type  rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  adpcm_pkg::hist_pair_type  wr_data,
   input  logic                      clr_en,
   input  logic [AW-1:0]             clr_addr
);

   adpcm_pkg::hist_pair_type mem [DEPTH];
   adpcm_pkg::hist_pair_type rd_data_ff;
   logic [DEPTH-1:0]         valid_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/adpcm_dp.sv =====
// ---------------------------------------------------------------------------
// adpcm_dp
// Sample datapath: two 16x16 predictor products in one stage, then scaled
// nibble, rounding bias, sum, shift and saturation. Holds the working history.
// ---------------------------------------------------------------------------
module adpcm_dp (
   input  logic                                  clock,
   input  adpcm_pkg::dp_ctl_type                 ctl,
   input  logic [adpcm_pkg::NIB_W-1:0]           nibble,
   input  logic [adpcm_pkg::EXP_W-1:0]           expo,
   input  adpcm_pkg::coef_pair_type              coef_rd,
   input  adpcm_pkg::hist_pair_type              hist_rd,
   output logic signed [adpcm_pkg::SAMPLE_W-1:0] sample,
   output adpcm_pkg::hist_pair_type              hist_next
);

   adpcm_pkg::coef_pair_type coef_ff;
   adpcm_pkg::hist_pair_type hist_ff;
   logic signed [adpcm_pkg::PROD_W-1:0]   prod1_ff, prod2_ff;

   logic signed [adpcm_pkg::SAMPLE_W-1:0] op_c1, op_c2, op_h1, op_h2;
   logic signed [adpcm_pkg::PROD_W-1:0]   prod1_c, prod2_c;
   logic signed [adpcm_pkg::NIB_W-1:0]    nib_s;
   logic [4:0]                            shamt;
   logic signed [adpcm_pkg::ACC_W-1:0]    nterm, acc, acc_sh;
   logic signed [22:0]                    scaled;

   function automatic logic signed [adpcm_pkg::ACC_W-1:0] ACC_SXT(
      input logic signed [adpcm_pkg::NIB_W-1:0] v);
      ACC_SXT = {{(adpcm_pkg::ACC_W-adpcm_pkg::NIB_W){v[adpcm_pkg::NIB_W-1]}}, v};
   endfunction

   // operand select: memories on the first nibble, working copy afterwards
   always_comb begin
      op_c1 = ctl.first ? coef_rd.c1 : coef_ff.c1;
      op_c2 = ctl.first ? coef_rd.c2 : coef_ff.c2;
      op_h1 = ctl.first ? hist_rd.h1 : hist_ff.h1;
      op_h2 = ctl.first ? hist_rd.h2 : hist_ff.h2;
      prod1_c = op_c1 * op_h1;
      prod2_c = op_c2 * op_h2;
   end

   // sum and saturate
   always_comb begin
      nib_s  = signed'(nibble);
      shamt  = {1'b0, expo} + 5'(adpcm_pkg::FRAC_BITS);
      nterm  = ACC_SXT(nib_s) <<< shamt;
      acc    = nterm + adpcm_pkg::ACC_W'(adpcm_pkg::ROUND_BIAS)
               + adpcm_pkg::ACC_W'(prod1_ff) + adpcm_pkg::ACC_W'(prod2_ff);
      acc_sh = acc >>> adpcm_pkg::FRAC_BITS;
      scaled = acc_sh[22:0];
      if (scaled > 23'(adpcm_pkg::SAMPLE_MAX)) begin
         sample = 16'(adpcm_pkg::SAMPLE_MAX);
      end else if (scaled < 23'(adpcm_pkg::SAMPLE_MIN)) begin
         sample = 16'(adpcm_pkg::SAMPLE_MIN);
      end else begin
         sample = scaled[15:0];
      end
      hist_next.h1 = sample;
      hist_next.h2 = hist_ff.h1;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         coef_ff.c1 <= op_c1;
         coef_ff.c2 <= op_c2;
         hist_ff.h1 <= op_h1;
         hist_ff.h2 <= op_h2;
         prod1_ff   <= prod1_c;
         prod2_ff   <= prod2_c;
      end else if (ctl.advance) begin
         hist_ff <= hist_next;
      end
   end

endmodule

// ===== tb/sv/adpcm_decoder_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adpcm_decoder_checker
// Watches both streams of the ADPCM decoder, predicts the decoded samples
// of every accepted request and compares each response transfer in order.
// ---------------------------------------------------------------------------
module adpcm_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          outstanding
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [2:0]                            chan;
      logic signed [adpcm_pkg::SAMPLE_W-1:0] pcm;
      logic                                  is_last;
   } pcm_result_type;

   // shadow of the decoder state
   logic signed [adpcm_pkg::SAMPLE_W-1:0] coef_mem [8][16];
   logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_one [8];
   logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_two [8];
   logic [7:0]                            hdr_byte [8];

   pcm_result_type expected_pcm [$];

   int err_count = 0;
   int pending   = 0;

   assign mismatches  = err_count;
   assign outstanding = pending;

   // one nibble through the predictor, history shifted
   function automatic logic signed [adpcm_pkg::SAMPLE_W-1:0] decode_nibble(
      int ch, logic [3:0] nib);
      logic [3:0]                            expo;
      logic [2:0]                            pair;
      longint                                n;
      longint                                acc;
      logic signed [adpcm_pkg::SAMPLE_W-1:0] pcm;
      expo = hdr_byte[ch][3:0];
      pair = hdr_byte[ch][6:4];   // bit 7 reserved
      n    = $signed(nib);
      acc  = (n <<< (expo + adpcm_pkg::FRAC_BITS)) + adpcm_pkg::ROUND_BIAS
           + longint'(coef_mem[ch][{pair, 1'b0}]) * longint'(hist_one[ch])
           + longint'(coef_mem[ch][{pair, 1'b1}]) * longint'(hist_two[ch]);
      acc  = acc >>> adpcm_pkg::FRAC_BITS;
      if (acc > adpcm_pkg::SAMPLE_MAX)      pcm = 16'sh7FFF;
      else if (acc < adpcm_pkg::SAMPLE_MIN) pcm = 16'sh8000;
      else                                  pcm = acc[adpcm_pkg::SAMPLE_W-1:0];
      hist_two[ch] = hist_one[ch];
      hist_one[ch] = pcm;
      return pcm;
   endfunction

   task automatic take_request(logic [39:0] tdata, adpcm_pkg::op_type op);
      int             ch;
      logic [7:0]     data_byte;
      int             count;
      pcm_result_type r;
      ch        = int'(tdata[2:0]);
      data_byte = tdata[10:3];
      count     = int'(tdata[12:11]);
      case (op)
         adpcm_pkg::OP_LOAD_COEF: coef_mem[ch][tdata[16:13]] = tdata[32:17];
         adpcm_pkg::OP_HEADER:    hdr_byte[ch] = data_byte;
         adpcm_pkg::OP_CLEAR: begin
            hist_one[ch] = '0;
            hist_two[ch] = '0;
         end
         adpcm_pkg::OP_DATA: begin
            if (count > 2) count = 2;
            for (int k = 0; k < count; k++) begin
               r.chan    = 3'(ch);
               r.pcm     = decode_nibble(ch, (k == 0) ? data_byte[7:4] : data_byte[3:0]);
               r.is_last = (k + 1 == count);
               expected_pcm.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_response(logic [23:0] tdata, logic tlast);
      pcm_result_type r;
      if (expected_pcm.size() == 0) begin
         err_count++;
         if (err_count <= REPORT_LIMIT)
            $display("%0t: unexpected sample ch %0d pcm %0d last %0b",
                     $time, tdata[2:0], $signed(tdata[18:3]), tlast);
         return;
      end
      r = expected_pcm.pop_front();
      if (tdata[2:0] !== r.chan || tdata[18:3] !== r.pcm || tlast !== r.is_last) begin
         err_count++;
         if (err_count <= REPORT_LIMIT)
            $display({"%0t: sample mismatch exp ch %0d pcm %0d last %0b, ",
                      "got ch %0d pcm %0d last %0b"},
                     $time, r.chan, r.pcm, r.is_last,
                     tdata[2:0], $signed(tdata[18:3]), tlast);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 8; c++) begin
            hist_one[c] = '0;
            hist_two[c] = '0;
            hdr_byte[c] = '0;
            for (int s = 0; s < 16; s++) coef_mem[c][s] = '0;
         end
         expected_pcm.delete();
      end else begin
         if (req_tvalid && req_tready)
            take_request(req_tdata, adpcm_pkg::op_type'(req_tuser));
         if (rsp_tvalid && rsp_tready) check_response(rsp_tdata, rsp_tlast);
      end
      pending = expected_pcm.size();
   end

endmodule

// ===== tb/sv/dsp_adpcm_decoder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dsp_adpcm_decoder_tb
// Drives coefficient loads, frame headers, data bytes and history clears
// into the ADPCM decoder under random back-pressure; the checker predicts
// and compares every decoded sample.
// ---------------------------------------------------------------------------
module dsp_adpcm_decoder_tb;

   localparam int ITEM_TARGET  = 650;
   localparam int IDLE_PCT     = 37;
   localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 20;
   localparam int BURST_FIRST  = 250;    // window of items sent with no idling at all opens here
   localparam int BURST_LAST   = 370;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // channel, data_byte, sample_count, coef_slot,
                                   // coef_value, zero fill
   logic [1:0]  req_tuser  = adpcm_pkg::OP_LOAD_COEF;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // out_channel, sample, zero fill
   logic        rsp_tlast;

   int   mismatches;
   int   outstanding;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   logic burst = 1'b0;

   // stimulus-side shadow: which coefficients have been written, and the
   // header each channel holds, so no data byte ever reads an unwritten entry
   logic [15:0] coef_written [8];
   logic [7:0]  hdr_shadow   [8];

   dsp_adpcm_decoder #(.MAX_CHANNELS(8)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   adpcm_decoder_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // sink back-pressure; never stalls during the burst window
   always @(posedge clock) begin
      rsp_tready <= burst ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // watchdog: any transfer on either side restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly Q11-sized taps, with the rails and full-range values now and then
   function automatic logic signed [15:0] coef_value();
      logic signed [15:0] v;
      case ($urandom_range(0, 9))
         0:       v = 16'sh7FFF;
         1:       v = 16'sh8000;
         2, 3:    v = 16'($urandom);
         default: v = 16'($urandom_range(0, 8191) - 4096);
      endcase
      return v;
   endfunction

   // random reserved bit and pair; exponents mostly moderate
   function automatic logic [7:0] header_byte();
      logic [3:0] expo;
      expo = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 11));
      return {1'($urandom), 3'($urandom), expo};
   endfunction

   // mostly pairs of nibbles; single nibbles, zero and three now and then
   function automatic logic [1:0] nibble_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 78)      return 2'd2;
      else if (r < 93) return 2'd1;
      else if (r < 97) return 2'd0;
      else             return 2'd3;
   endfunction

   // One request transfer. Valid stays high between back-to-back items and
   // is only lowered when an idle gap is taken.
   task automatic send(adpcm_pkg::op_type op, logic [2:0] ch, logic [7:0] data_byte,
                       logic [1:0] count, logic [3:0] slot, logic [15:0] value);
      if (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!burst && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, value, slot, count, data_byte, ch};
      do @(posedge clock); while (!req_tready);
      if (op == adpcm_pkg::OP_LOAD_COEF) coef_written[ch][slot] = 1'b1;
      if (op == adpcm_pkg::OP_HEADER)    hdr_shadow[ch] = data_byte;
      items_sent++;
      burst = (items_sent >= BURST_FIRST && items_sent < BURST_LAST);
   endtask

   // write any coefficient of the channel's current pair not yet loaded
   task automatic load_missing_pair(logic [2:0] ch);
      logic [3:0] slot;
      for (int k = 0; k < 2; k++) begin
         slot = {hdr_shadow[ch][6:4], 1'(k)};
         if (!coef_written[ch][slot])
            send(adpcm_pkg::OP_LOAD_COEF, ch, 8'($urandom), 2'($urandom), slot,
                 coef_value());
      end
   endtask

   // well-formed frame: optional fresh taps and clear, header, data bytes
   task automatic random_frame();
      logic [2:0] ch;
      logic [7:0] hdr;
      ch  = 3'($urandom_range(0, 7));
      hdr = header_byte();
      if ($urandom_range(0, 2) == 0) begin
         send(adpcm_pkg::OP_LOAD_COEF, ch, 8'($urandom), 2'($urandom),
              {hdr[6:4], 1'b0}, coef_value());
         send(adpcm_pkg::OP_LOAD_COEF, ch, 8'($urandom), 2'($urandom),
              {hdr[6:4], 1'b1}, coef_value());
      end
      if ($urandom_range(0, 4) == 0)
         send(adpcm_pkg::OP_CLEAR, ch, 8'($urandom), 2'($urandom), 4'($urandom),
              16'($urandom));
      send(adpcm_pkg::OP_HEADER, ch, hdr, 2'($urandom), 4'($urandom), 16'($urandom));
      load_missing_pair(ch);
      repeat ($urandom_range(1, 8))
         send(adpcm_pkg::OP_DATA, ch, 8'($urandom), nibble_count(), 4'($urandom),
              16'($urandom));
   endtask

   // noise: any operation on any channel with random fields
   task automatic random_item();
      adpcm_pkg::op_type op;
      logic [2:0]        ch;
      op = adpcm_pkg::op_type'($urandom_range(0, 3));
      ch = 3'($urandom_range(0, 7));
      if (op == adpcm_pkg::OP_DATA) load_missing_pair(ch);
      send(op, ch, 8'($urandom), 2'($urandom), 4'($urandom), 16'($urandom));
   endtask

   initial begin
      for (int c = 0; c < 8; c++) begin
         coef_written[c] = '0;
         hdr_shadow[c]   = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // channel 0, pair 0 at the rails, exponent 0: +7 then -1, then -8 alone
      send(adpcm_pkg::OP_LOAD_COEF, 3'd0, 8'h00, 2'd0, 4'd0, 16'h7FFF);
      send(adpcm_pkg::OP_LOAD_COEF, 3'd0, 8'hFF, 2'd3, 4'd1, 16'h8000);
      send(adpcm_pkg::OP_HEADER,    3'd0, 8'h00, 2'd0, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h7F, 2'd2, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h80, 2'd1, 4'd0, 16'h0000);
      // reserved header bit set, largest exponent: both rails saturate
      send(adpcm_pkg::OP_HEADER,    3'd0, 8'h8F, 2'd0, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h78, 2'd2, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h87, 2'd2, 4'd0, 16'h0000);
      // zero count decodes nothing, three is taken as two
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h5A, 2'd0, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'hA5, 2'd3, 4'd0, 16'h0000);
      // history clear, then a decode from silence
      send(adpcm_pkg::OP_CLEAR,     3'd0, 8'hFF, 2'd3, 4'd15, 16'hFFFF);
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h10, 2'd1, 4'd0, 16'h0000);
      // channel 7, top pair, rails swapped, reserved bit set with exponent 0
      send(adpcm_pkg::OP_LOAD_COEF, 3'd7, 8'h00, 2'd0, 4'd14, 16'h8000);
      send(adpcm_pkg::OP_LOAD_COEF, 3'd7, 8'h00, 2'd0, 4'd15, 16'h7FFF);
      send(adpcm_pkg::OP_HEADER,    3'd7, 8'hF0, 2'd0, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd7, 8'hFF, 2'd2, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd7, 8'h7F, 2'd2, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_HEADER,    3'd7, 8'h7F, 2'd0, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd7, 8'h00, 2'd2, 4'd0, 16'h0000);
      send(adpcm_pkg::OP_DATA,      3'd7, 8'h88, 2'd2, 4'd0, 16'h0000);
      // channel 0 keeps its own state while 7 ran
      send(adpcm_pkg::OP_DATA,      3'd0, 8'h33, 2'd2, 4'd0, 16'h0000);

      // --- random part: mostly frames, some noise ---
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) random_item();
         else                           random_frame();
      end
      req_tvalid <= 1'b0;

      // drain, then allow for anything the block might still emit
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
